FILE: rtl/contact_impulse_resolver_macros.svh
// ----------------------------------------------------------------------------
// contact impulse resolver assertion macros
// clocked property checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef CONTACT_IMPULSE_RESOLVER_MACROS_SVH
`define CONTACT_IMPULSE_RESOLVER_MACROS_SVH

`ifndef SYNTHESIS
`define CIR_ASSERT_CLK(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);
`define CIR_ASSERT(lbl, prop, msg) `CIR_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`else
`define CIR_ASSERT_CLK(lbl, ck, rstn, prop, msg)
`define CIR_ASSERT(lbl, prop, msg)
`endif

`endif

FILE: rtl/cir_pkg.sv
// ----------------------------------------------------------------------------
// cir_pkg
// types, constants and saturating fixed point helpers for the contact resolver
// ----------------------------------------------------------------------------
package cir_pkg;

  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 16;
  localparam int REST_BITS    = 16;
  localparam int REST_W       = 17;
  localparam int MASS_W       = WORD_BITS - 1;
  localparam int FLAG_W       = 2;
  localparam int FRONT_STAGES = 7;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = 2;
  localparam int DIV_STEPS    = WORD_BITS + FRAC_BITS;
  localparam int PROD_W       = 2 * WORD_BITS + 2;
  localparam int IN_RAW       = 8 * WORD_BITS + REST_W + 2 * MASS_W + FLAG_W;
  localparam int IN_W         = ((IN_RAW + 7) / 8) * 8;
  localparam int IN_PAD       = IN_W - IN_RAW;
  localparam int OUT_W        = 9 * WORD_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [WORD_BITS:0]   wide_t;
  typedef logic [MASS_W-1:0]           mass_t;
  typedef logic [REST_W-1:0]           rest_t;
  typedef logic [FLAG_W-1:0]           flags_t;

  localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam mass_t TS_RESET = mass_t'(1092);
  localparam logic signed [PROD_W-1:0] PROD_ONE = 1;

  // input beat, first field in the low bits
  typedef struct packed {
    logic [IN_PAD-1:0] pad;
    flags_t flags;
    word_t  accn;
    mass_t  ib;
    mass_t  ia;
    word_t  bvy;
    word_t  bvx;
    word_t  avy;
    word_t  avx;
    rest_t  rest;
    word_t  pen;
    word_t  ny;
    word_t  nx;
  } in_t;

  // output beat, first field in the low bits
  typedef struct packed {
    word_t imp;
    word_t vby;
    word_t vbx;
    word_t vay;
    word_t vax;
    word_t pby;
    word_t pbx;
    word_t pay;
    word_t pax;
  } out_t;

  typedef struct packed {
    word_t nx;
    word_t ny;
    word_t pen;
    word_t avx;
    word_t avy;
    word_t bvx;
    word_t bvy;
    word_t accn;
    rest_t rest;
    mass_t ia;
    mass_t ib;
    flags_t flags;
    logic [WORD_BITS-1:0] tim;
    logic  tim_zero;
    logic  sep_pos;
    word_t dvx;
    word_t dvy;
    word_t acl;
    word_t aclr;
    word_t px;
    word_t py;
    word_t sep;
    word_t nsep;
    word_t dv;
  } item_t;

  typedef struct packed {
    word_t nx;
    word_t ny;
    word_t avx;
    word_t avy;
    word_t bvx;
    word_t bvy;
    mass_t ia;
    mass_t ib;
    flags_t flags;
    logic  tim_zero;
    logic  no_imp;
  } ctx_t;

  typedef struct packed {
    ctx_t  ctx;
    word_t per;
    word_t imp;
    word_t mx;
    word_t my;
    word_t ix;
    word_t iy;
    word_t pax;
    word_t pay;
    word_t pbx;
    word_t pby;
    word_t dax;
    word_t day;
    word_t dbx;
    word_t dby;
  } back_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic word_t clamp(input wide_t s);
    word_t res;
    if (s > WMAX) res = WMAX;
    else if (s < WMIN) res = WMIN;
    else res = s[WORD_BITS-1:0];
    return res;
  endfunction

  function automatic wide_t sx(input word_t a);
    return wide_t'(a);
  endfunction

  function automatic wide_t ux(input mass_t m);
    return wide_t'({2'b00, m});
  endfunction

  function automatic wide_t mneg(input mass_t m);
    return -ux(m);
  endfunction

  function automatic wide_t rx(input rest_t r);
    return wide_t'({{(WORD_BITS+1-REST_W){1'b0}}, r});
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    return clamp(sx(a) + sx(b));
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    return clamp(sx(a) - sx(b));
  endfunction

  function automatic word_t sat_neg(input word_t a);
    return (a == WMIN) ? WMAX : -a;
  endfunction

  // (a * b) >> sh, toward zero, saturated
  function automatic word_t mul_sh(input wide_t a, input wide_t b, input int sh);
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] rnd;
    logic signed [PROD_W-1:0] q;
    word_t res;
    p   = a * b;
    rnd = '0;
    if (p[PROD_W-1]) rnd = (PROD_ONE << sh) - PROD_ONE;
    q = (p + rnd) >>> sh;
    if (q > WMAX) res = WMAX;
    else if (q < WMIN) res = WMIN;
    else res = q[WORD_BITS-1:0];
    return res;
  endfunction

endpackage

FILE: rtl/cir_div.sv
// ----------------------------------------------------------------------------
// cir_div
// pipelined restoring divider, (num << frac) / den, one quotient bit per stage
// ----------------------------------------------------------------------------
module cir_div (
  input  logic                               clk,
  input  logic                               en,
  input  cir_pkg::word_t                     num,
  input  logic [cir_pkg::WORD_BITS-1:0]      den,
  output cir_pkg::word_t                     quo
);

  localparam int W  = cir_pkg::WORD_BITS;
  localparam int NS = cir_pkg::DIV_STEPS;

  logic [W-1:0]  rem_r [NS];
  logic [NS-1:0] nq_r  [NS];
  logic [W-1:0]  den_r [NS];
  logic          neg_r [NS];

  logic [W-1:0]  num_u;
  logic [W-1:0]  mag;
  logic [NS-1:0] q;
  logic          over;

  assign num_u = num;
  assign mag   = num_u[W-1] ? (~num_u + {{(W-1){1'b0}}, 1'b1}) : num_u;

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [W-1:0]  rem_in;
    logic [NS-1:0] nq_in;
    logic [W-1:0]  den_in;
    logic          neg_in;
    logic [W:0]    r_try;
    logic [W:0]    diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = {mag, {cir_pkg::FRAC_BITS{1'b0}}};
      assign den_in = den;
      assign neg_in = num_u[W-1];
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign nq_in  = nq_r[k-1];
      assign den_in = den_r[k-1];
      assign neg_in = neg_r[k-1];
    end

    assign r_try = {rem_in, nq_in[NS-1]};
    assign diff  = r_try - {1'b0, den_in};
    assign ge    = r_try >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[W-1:0] : r_try[W-1:0];
        nq_r[k]  <= {nq_in[NS-2:0], ge};
        den_r[k] <= den_in;
        neg_r[k] <= neg_in;
      end
    end
  end

  assign q    = nq_r[NS-1];
  assign over = |q[NS-1:W-1];

  always_comb begin
    if (neg_r[NS-1]) begin
      quo = over ? cir_pkg::WMIN : -q[W-1:0];
    end else begin
      quo = over ? cir_pkg::WMAX : q[W-1:0];
    end
  end

endmodule

FILE: rtl/cir_front.sv
// ----------------------------------------------------------------------------
// cir_front
// accepts contacts, computes closing speed, bounce target and velocity change
// ----------------------------------------------------------------------------
module cir_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [cir_pkg::IN_W-1:0]      in_tdata,
  input  cir_pkg::mass_t                time_step,
  input  cir_pkg::fifo_stat_t           fstat,
  output logic                          push,
  output cir_pkg::item_t                item
);

  localparam int NF = cir_pkg::FRONT_STAGES;

  cir_pkg::item_t st_r   [NF];
  cir_pkg::item_t st_nxt [NF];
  logic [NF-1:0]  v_r;
  logic           en;
  cir_pkg::in_t   pkt;

  assign pkt       = in_tdata;
  assign en        = !(v_r[NF-1] && fstat.full);
  assign in_tready = en;
  assign push      = v_r[NF-1] && !fstat.full;
  assign item      = st_r[NF-1];

  always_comb begin
    cir_pkg::word_t t;
    t = '0;

    st_nxt[0]       = '0;
    st_nxt[0].nx    = pkt.nx;
    st_nxt[0].ny    = pkt.ny;
    st_nxt[0].pen   = pkt.pen;
    st_nxt[0].rest  = pkt.rest;
    st_nxt[0].avx   = pkt.avx;
    st_nxt[0].avy   = pkt.avy;
    st_nxt[0].bvx   = pkt.bvx;
    st_nxt[0].bvy   = pkt.bvy;
    st_nxt[0].ia    = pkt.ia;
    st_nxt[0].ib    = pkt.ib;
    st_nxt[0].accn  = pkt.accn;
    st_nxt[0].flags = pkt.flags;

    st_nxt[1]          = st_r[0];
    st_nxt[1].tim      = {1'b0, st_r[0].ia} + {1'b0, st_r[0].ib};
    st_nxt[1].tim_zero = (st_r[0].ia == '0) && (st_r[0].ib == '0);
    st_nxt[1].dvx      = cir_pkg::sat_sub(st_r[0].avx, st_r[0].bvx);
    st_nxt[1].dvy      = cir_pkg::sat_sub(st_r[0].avy, st_r[0].bvy);
    st_nxt[1].acl      = cir_pkg::mul_sh(cir_pkg::sx(st_r[0].accn), cir_pkg::ux(time_step),
                                         cir_pkg::FRAC_BITS);

    st_nxt[2]      = st_r[1];
    st_nxt[2].px   = cir_pkg::mul_sh(cir_pkg::sx(st_r[1].dvx), cir_pkg::sx(st_r[1].nx),
                                     cir_pkg::FRAC_BITS);
    st_nxt[2].py   = cir_pkg::mul_sh(cir_pkg::sx(st_r[1].dvy), cir_pkg::sx(st_r[1].ny),
                                     cir_pkg::FRAC_BITS);
    st_nxt[2].aclr = cir_pkg::mul_sh(cir_pkg::sx(st_r[1].acl), cir_pkg::rx(st_r[1].rest),
                                     cir_pkg::REST_BITS);

    st_nxt[3]     = st_r[2];
    st_nxt[3].sep = cir_pkg::sat_add(st_r[2].px, st_r[2].py);

    st_nxt[4]      = st_r[3];
    st_nxt[4].nsep = cir_pkg::mul_sh(cir_pkg::sx(cir_pkg::sat_neg(st_r[3].sep)),
                                     cir_pkg::rx(st_r[3].rest), cir_pkg::REST_BITS);

    // acceleration-caused closing comes off the bounce
    st_nxt[5] = st_r[4];
    t = cir_pkg::sat_add(st_r[4].nsep, st_r[4].aclr);
    if (st_r[4].acl < 0) begin
      st_nxt[5].nsep = (t < 0) ? '0 : t;
    end

    st_nxt[6]         = st_r[5];
    st_nxt[6].dv      = cir_pkg::sat_sub(st_r[5].nsep, st_r[5].sep);
    st_nxt[6].sep_pos = st_r[5].sep > 0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NF-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule

FILE: rtl/cir_fifo.sv
// ----------------------------------------------------------------------------
// cir_fifo
// short queue of classified contacts between front and back
// ----------------------------------------------------------------------------
`include "contact_impulse_resolver_macros.svh"

module cir_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cir_pkg::item_t      din,
  input  logic                pop,
  output cir_pkg::item_t      dout,
  output cir_pkg::fifo_stat_t stat
);

  localparam int AW = cir_pkg::FIFO_AW;

  cir_pkg::item_t mem_r [cir_pkg::FIFO_DEPTH];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [AW:0]    cnt_r;
  logic [AW:0]    cnt_nxt;

  assign dout       = mem_r[rd_ptr_r];
  assign stat.full  = cnt_r == (AW+1)'(cir_pkg::FIFO_DEPTH);
  assign stat.empty = cnt_r == '0;

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  `CIR_ASSERT(a_fifo_fill, (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1), "fill count")
  `CIR_ASSERT(a_fifo_pop, pop |-> (cnt_r != '0), "pop from empty queue")

endmodule

FILE: rtl/cir_back.sv
// ----------------------------------------------------------------------------
// cir_back
// divides by total inverse mass and applies corrections and impulse
// ----------------------------------------------------------------------------
`include "contact_impulse_resolver_macros.svh"

module cir_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cir_pkg::item_t                head,
  input  cir_pkg::fifo_stat_t           fstat,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cir_pkg::OUT_W-1:0]     out_tdata
);

  localparam int NS = cir_pkg::DIV_STEPS;
  localparam int FB = cir_pkg::FRAC_BITS;

  cir_pkg::ctx_t  ctx_r [NS];
  cir_pkg::ctx_t  ctx_in;
  logic [NS-1:0]  cv_r;
  logic [3:0]     pv_r;
  logic           en;
  cir_pkg::word_t per_q;
  cir_pkg::word_t imp_q;
  cir_pkg::back_t s1_r, s2_r, s3_r;
  cir_pkg::back_t s1_nxt, s2_nxt, s3_nxt;
  cir_pkg::out_t  out_r, out_nxt;

  assign en         = !pv_r[3] || out_tready;
  assign pop        = en && !fstat.empty;
  assign out_tvalid = pv_r[3];
  assign out_tdata  = out_r;

  cir_div u_div_pen (
    .clk (clk),
    .en  (en),
    .num (head.pen),
    .den (head.tim),
    .quo (per_q)
  );

  cir_div u_div_imp (
    .clk (clk),
    .en  (en),
    .num (head.dv),
    .den (head.tim),
    .quo (imp_q)
  );

  always_comb begin
    ctx_in.nx       = head.nx;
    ctx_in.ny       = head.ny;
    ctx_in.avx      = head.avx;
    ctx_in.avy      = head.avy;
    ctx_in.bvx      = head.bvx;
    ctx_in.bvy      = head.bvy;
    ctx_in.ia       = head.ia;
    ctx_in.ib       = head.ib;
    ctx_in.flags    = head.flags;
    ctx_in.tim_zero = head.tim_zero;
    ctx_in.no_imp   = head.tim_zero || head.sep_pos;
  end

  always_comb begin
    s1_nxt     = '0;
    s1_nxt.ctx = ctx_r[NS-1];
    s1_nxt.per = per_q;
    s1_nxt.imp = imp_q;

    s2_nxt    = s1_r;
    s2_nxt.mx = cir_pkg::mul_sh(cir_pkg::sx(s1_r.ctx.nx), cir_pkg::sx(s1_r.per), FB);
    s2_nxt.my = cir_pkg::mul_sh(cir_pkg::sx(s1_r.ctx.ny), cir_pkg::sx(s1_r.per), FB);
    s2_nxt.ix = cir_pkg::mul_sh(cir_pkg::sx(s1_r.ctx.nx), cir_pkg::sx(s1_r.imp), FB);
    s2_nxt.iy = cir_pkg::mul_sh(cir_pkg::sx(s1_r.ctx.ny), cir_pkg::sx(s1_r.imp), FB);

    s3_nxt     = s2_r;
    s3_nxt.pax = cir_pkg::mul_sh(cir_pkg::sx(s2_r.mx), cir_pkg::ux(s2_r.ctx.ia), FB);
    s3_nxt.pay = cir_pkg::mul_sh(cir_pkg::sx(s2_r.my), cir_pkg::ux(s2_r.ctx.ia), FB);
    s3_nxt.pbx = cir_pkg::mul_sh(cir_pkg::sx(s2_r.mx), cir_pkg::mneg(s2_r.ctx.ib), FB);
    s3_nxt.pby = cir_pkg::mul_sh(cir_pkg::sx(s2_r.my), cir_pkg::mneg(s2_r.ctx.ib), FB);
    s3_nxt.dax = cir_pkg::mul_sh(cir_pkg::sx(s2_r.ix), cir_pkg::ux(s2_r.ctx.ia), FB);
    s3_nxt.day = cir_pkg::mul_sh(cir_pkg::sx(s2_r.iy), cir_pkg::ux(s2_r.ctx.ia), FB);
    s3_nxt.dbx = cir_pkg::mul_sh(cir_pkg::sx(s2_r.ix), cir_pkg::mneg(s2_r.ctx.ib), FB);
    s3_nxt.dby = cir_pkg::mul_sh(cir_pkg::sx(s2_r.iy), cir_pkg::mneg(s2_r.ctx.ib), FB);

    // zero total inverse mass moves nothing, static bodies keep their place
    out_nxt = '0;
    if (!s3_r.ctx.tim_zero && !s3_r.ctx.flags[0]) begin
      out_nxt.pax = s3_r.pax;
      out_nxt.pay = s3_r.pay;
    end
    if (!s3_r.ctx.tim_zero && !s3_r.ctx.flags[1]) begin
      out_nxt.pbx = s3_r.pbx;
      out_nxt.pby = s3_r.pby;
    end
    if (s3_r.ctx.no_imp) begin
      out_nxt.vax = s3_r.ctx.avx;
      out_nxt.vay = s3_r.ctx.avy;
      out_nxt.vbx = s3_r.ctx.bvx;
      out_nxt.vby = s3_r.ctx.bvy;
    end else begin
      out_nxt.vax = cir_pkg::sat_add(s3_r.ctx.avx, s3_r.dax);
      out_nxt.vay = cir_pkg::sat_add(s3_r.ctx.avy, s3_r.day);
      out_nxt.vbx = cir_pkg::sat_add(s3_r.ctx.bvx, s3_r.dbx);
      out_nxt.vby = cir_pkg::sat_add(s3_r.ctx.bvy, s3_r.dby);
      out_nxt.imp = s3_r.imp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= '0;
      pv_r <= '0;
    end else if (en) begin
      cv_r <= {cv_r[NS-2:0], pop};
      pv_r <= {pv_r[2:0], cv_r[NS-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0] <= ctx_in;
      for (int k = 1; k < NS; k++) begin
        ctx_r[k] <= ctx_r[k-1];
      end
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      out_r <= out_nxt;
    end
  end

  `CIR_ASSERT(a_no_impulse, (pv_r[2] && en && s3_r.ctx.no_imp) |=> (out_r.imp == '0), "impulse")
  `CIR_ASSERT(a_hold_stall, (pv_r[3] && !out_tready) |=> (pv_r[3] && $stable(out_r)), "stall")

endmodule

FILE: rtl/contact_impulse_resolver.sv
// ----------------------------------------------------------------------------
// contact_impulse_resolver
// two-body contact resolution with restitution, Q16.16 saturating
// ----------------------------------------------------------------------------
// in_*  : one contact per beat, tvalid/tready handshake
// out_* : position corrections, new velocities and impulse, one beat per contact
// cfg_* : time_step written on any clock with cfg_wr_en high outside reset
// one contact enters every cycle while in_tready is high; the path is a
// 7-stage front, one queue slot, the two 48-stage dividers (one quotient bit
// per stage) and four multiply and apply stages
// results come out in input order
// reset empties all stages and the queue and loads time_step with 1092
// when out_tready is low the back pipeline holds and the output beat stays
// the front keeps taking beats until the 4-entry queue is full, then
// in_tready drops
// ----------------------------------------------------------------------------
module contact_impulse_resolver (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // normal_x, normal_y, penetration, restitution, a_velocity_x, a_velocity_y,
  // b_velocity_x, b_velocity_y, a_inv_mass, b_inv_mass, accel_diff_normal,
  // static_flags, zero pad
  input  logic [cir_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // a_position_delta_x, a_position_delta_y, b_position_delta_x,
  // b_position_delta_y, a_new_velocity_x, a_new_velocity_y,
  // b_new_velocity_x, b_new_velocity_y, impulse
  output logic [cir_pkg::OUT_W-1:0]     out_tdata,
  input  logic                          cfg_wr_en,
  input  cir_pkg::mass_t                cfg_wr_data
);

  cir_pkg::mass_t      time_step_r;
  cir_pkg::item_t      f_item;
  cir_pkg::item_t      q_head;
  cir_pkg::fifo_stat_t fstat;
  logic                push;
  logic                pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= cir_pkg::TS_RESET;
    end else if (cfg_wr_en) begin
      time_step_r <= cfg_wr_data;
    end
  end

  cir_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .time_step (time_step_r),
    .fstat     (fstat),
    .push      (push),
    .item      (f_item)
  );

  cir_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (f_item),
    .pop   (pop),
    .dout  (q_head),
    .stat  (fstat)
  );

  cir_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .fstat      (fstat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: tb/tb_contact_impulse_resolver.sv
// ----------------------------------------------------------------------------
// tb_contact_impulse_resolver
// streams contacts through the resolver under random valid and ready gaps,
// predicts every result beat in fixed point and checks it field by field,
// over several time_step settings including both extremes
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_contact_impulse_resolver;
  import cir_pkg::*;

  localparam int RAND_ITEMS = 530;
  localparam int DOG_LIMIT  = 20000;
  localparam int DRAIN      = 80;

  typedef struct {
    in_t  x;
    bit   known;
    out_t y;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  mass_t cfg_wr_data = '0;

  out_t  pending_results[$];
  mass_t step_time = TS_RESET;
  row_t  rows[$];
  int    fail_count = 0;
  int    beats_in = 0;
  int    beats_out = 0;
  int    quiet_cycles = 0;
  bit    no_idle = 1'b0;
  bit    stim_done = 1'b0;

  contact_impulse_resolver dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint clampw(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 64'sd2147483647;
    if (v < -128'sd2147483648) return -64'sd2147483648;
    return longint'(v);
  endfunction

  function automatic longint qmul(longint a, longint b, int sh);
    logic signed [127:0] pa, pb, p, m;
    pa = 128'(a);
    pb = 128'(b);
    p = pa * pb;
    m = (p < 0) ? -p : p;
    m = m >>> sh;
    return clampw((p < 0) ? -m : m);
  endfunction

  function automatic longint qdiv(longint n, longint d);
    logic [127:0] m, q;
    logic signed [127:0] r;
    m = 128'((n < 0) ? -n : n);
    q = (m << FRAC_BITS) / 128'(d);
    if (q > 128'd4294967296) q = 128'd4294967296;
    r = $signed(q);
    return clampw((n < 0) ? -r : r);
  endfunction

  function automatic out_t resolve_contact(in_t x, mass_t ts);
    longint nx, ny, pen, rst, avx, avy, bvx, bvy, ia, ib, accn, tim;
    longint per, mx, my, sep, nsep, acl, dv, imp, ix, iy;
    out_t y;
    nx = longint'(x.nx); ny = longint'(x.ny); pen = longint'(x.pen);
    rst = {47'd0, x.rest};
    avx = longint'(x.avx); avy = longint'(x.avy);
    bvx = longint'(x.bvx); bvy = longint'(x.bvy);
    ia = {33'd0, x.ia}; ib = {33'd0, x.ib};
    accn = longint'(x.accn);
    tim = ia + ib;
    y = '0;
    y.vax = word_t'(avx); y.vay = word_t'(avy);
    y.vbx = word_t'(bvx); y.vby = word_t'(bvy);
    if (tim != 0) begin
      per = qdiv(pen, tim);
      mx = qmul(nx, per, FRAC_BITS);
      my = qmul(ny, per, FRAC_BITS);
      if (!x.flags[0]) begin
        y.pax = word_t'(qmul(mx, ia, FRAC_BITS));
        y.pay = word_t'(qmul(my, ia, FRAC_BITS));
      end
      if (!x.flags[1]) begin
        y.pbx = word_t'(qmul(mx, -ib, FRAC_BITS));
        y.pby = word_t'(qmul(my, -ib, FRAC_BITS));
      end
      sep = clampw(qmul(clampw(avx - bvx), nx, FRAC_BITS)
                   + qmul(clampw(avy - bvy), ny, FRAC_BITS));
      if (sep <= 0) begin
        nsep = qmul(clampw(-sep), rst, REST_BITS);
        acl = qmul(accn, {33'd0, ts}, FRAC_BITS);
        if (acl < 0) begin
          nsep = clampw(nsep + qmul(acl, rst, REST_BITS));
          if (nsep < 0) nsep = 0;
        end
        dv = clampw(nsep - sep);
        imp = qdiv(dv, tim);
        ix = qmul(nx, imp, FRAC_BITS);
        iy = qmul(ny, imp, FRAC_BITS);
        y.vax = word_t'(clampw(avx + qmul(ix, ia, FRAC_BITS)));
        y.vay = word_t'(clampw(avy + qmul(iy, ia, FRAC_BITS)));
        y.vbx = word_t'(clampw(bvx + qmul(ix, -ib, FRAC_BITS)));
        y.vby = word_t'(clampw(bvy + qmul(iy, -ib, FRAC_BITS)));
        y.imp = word_t'(imp);
      end
    end
    return y;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom);
      1: return word_t'(int'($urandom_range(0, 524288)) - 262144);
      2: return word_t'(int'($urandom_range(0, 131072)) - 65536);
      3: case ($urandom_range(0, 3))
           0: return WMAX;
           1: return WMIN;
           2: return '0;
           default: return '1;
         endcase
      default: return word_t'(int'($urandom_range(0, 8388608)) - 4194304);
    endcase
  endfunction

  function automatic mass_t rand_mass();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return mass_t'($urandom);
      2: return '1;
      default: return mass_t'($urandom_range(0, 262144));
    endcase
  endfunction

  function automatic in_t rand_contact();
    in_t x;
    x = '0;
    x.nx = rand_word();
    x.ny = rand_word();
    x.pen = rand_word();
    x.rest = ($urandom_range(0, 7) == 0) ? rest_t'($urandom)
                                         : rest_t'($urandom_range(0, 65536));
    x.avx = rand_word();
    x.avy = rand_word();
    x.bvx = rand_word();
    x.bvy = rand_word();
    x.ia = rand_mass();
    x.ib = rand_mass();
    x.accn = rand_word();
    x.flags = flags_t'($urandom_range(0, 3));
    return x;
  endfunction

  function automatic in_t mk(word_t nx, word_t ny, word_t pen, rest_t rst,
                             word_t avx, word_t avy, word_t bvx, word_t bvy,
                             mass_t ia, mass_t ib, word_t accn, flags_t fl);
    in_t x;
    x = '0;
    x.nx = nx; x.ny = ny; x.pen = pen; x.rest = rst;
    x.avx = avx; x.avy = avy; x.bvx = bvx; x.bvy = bvy;
    x.ia = ia; x.ib = ib; x.accn = accn; x.flags = fl;
    return x;
  endfunction

  task automatic add_row(in_t x, bit known, out_t y);
    row_t r;
    r.x = x;
    r.known = known;
    r.y = y;
    rows.insert(rows.size(), r);
  endtask

  task automatic build_table();
    in_t x;
    out_t y;
    // all zero, zero total inverse mass
    add_row('0, 1'b1, '0);
    // zero total inverse mass passes velocities through
    x = mk(32'sd65536, 0, 32'sd65536, 17'd65536, WMAX, WMIN, -1, 32'sd7,
           '0, '0, WMIN, 2'd0);
    y = '0;
    y.vax = WMAX; y.vay = WMIN; y.vbx = -1; y.vby = 32'sd7;
    add_row(x, 1'b1, y);
    add_row(mk(WMAX, WMAX, WMAX, 17'h1ffff, WMAX, WMAX, WMAX, WMAX, '1, '1,
               WMAX, 2'd0), 1'b0, '0);
    add_row(mk(WMIN, WMIN, WMIN, '0, WMIN, WMIN, WMIN, WMIN, '1, '1, WMIN,
               2'd3), 1'b0, '0);
    // separating
    add_row(mk(32'sd65536, 0, 32'sd6554, 17'd32768, 32'sd65536, 0,
               -32'sd65536, 0, 31'd65536, 31'd65536, 0, 2'd0), 1'b0, '0);
    // head-on closing
    add_row(mk(32'sd65536, 0, 32'sd6554, 17'd32768, -32'sd65536, 0,
               32'sd65536, 0, 31'd65536, 31'd65536, 0, 2'd0), 1'b0, '0);
    add_row(mk(0, -32'sd65536, 32'sd3000, 17'd65536, 0, -32'sd131072, 0, 0,
               31'd65536, 31'd131072, 0, 2'd1), 1'b0, '0);
    add_row(mk(0, -32'sd65536, 32'sd3000, 17'd65536, 0, -32'sd131072, 0, 0,
               31'd65536, 31'd131072, 0, 2'd2), 1'b0, '0);
    // negative acceleration while separating, full bounce and none
    add_row(mk(32'sd46341, 32'sd46341, 32'sd9000, 17'd65536, 32'sd98304,
               32'sd98304, 0, 0, 31'd65536, '0, -32'sd655360, 2'd2), 1'b0, '0);
    add_row(mk(32'sd46341, 32'sd46341, 32'sd9000, 17'd0, 32'sd98304,
               32'sd98304, 0, 0, 31'd65536, '0, -32'sd655360, 2'd2), 1'b0, '0);
    add_row(mk(32'sd65536, 0, 32'sd100, 17'd80000, 32'sd65536, 0, 0, 0,
               '0, 31'd32768, 32'sd655360, 2'd1), 1'b0, '0);
    // negative penetration, restitution above one
    add_row(mk(-32'sd65536, 0, -32'sd20000, 17'h1ffff, -32'sd65536, 0, 0, 0,
               31'd1, 31'd1, -32'sd1, 2'd0), 1'b0, '0);
    add_row(mk(32'sd1, -32'sd1, 32'sd1, 17'd1, 32'sd1, -32'sd1, -32'sd1,
               32'sd1, 31'd1, '1, WMIN, 2'd3), 1'b0, '0);
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %08h expected %08h", what, got, want);
    fail_count++;
  endtask

  task automatic check_beat(out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      $display("unexpected result beat %h", got);
      fail_count++;
      return;
    end
    want = pending_results.pop_front();
    if (got.pax !== want.pax) report("a_position_delta_x", got.pax, want.pax);
    if (got.pay !== want.pay) report("a_position_delta_y", got.pay, want.pay);
    if (got.pbx !== want.pbx) report("b_position_delta_x", got.pbx, want.pbx);
    if (got.pby !== want.pby) report("b_position_delta_y", got.pby, want.pby);
    if (got.vax !== want.vax) report("a_new_velocity_x", got.vax, want.vax);
    if (got.vay !== want.vay) report("a_new_velocity_y", got.vay, want.vay);
    if (got.vbx !== want.vbx) report("b_new_velocity_x", got.vbx, want.vbx);
    if (got.vby !== want.vby) report("b_new_velocity_y", got.vby, want.vby);
    if (got.imp !== want.imp) report("impulse", got.imp, want.imp);
  endtask

  // called just after a posedge, leaves us just after the accepting posedge
  task automatic send_contact(in_t x, bit known, out_t y);
    while (!no_idle && $urandom_range(0, 99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= x;
    forever begin
      @(negedge clk);
      if (in_tready) break;
      @(posedge clk);
    end
    @(posedge clk);
    pending_results.insert(pending_results.size(),
                           known ? y : resolve_contact(x, step_time));
    beats_in++;
  endtask

  task automatic drain_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_step(mass_t v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    step_time = v;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        // hold off until the pipe is empty
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_contact(rand_contact(), 1'b0, '0);
    end
  endtask

  // result side
  initial begin
    forever begin
      @(negedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        check_beat(out_t'(out_tdata));
        beats_out++;
      end
      @(posedge clk);
      out_tready <= no_idle || ($urandom_range(0, 99) >= 25);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= DOG_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("FAIL contact_impulse_resolver");
      $finish;
    end
  end

  initial begin
    build_table();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send_contact(rows[i].x, rows[i].known, rows[i].y);
    drain_idle();
    run_random(RAND_ITEMS / 6);
    drain_idle();
    write_step('0);
    run_random(RAND_ITEMS / 6);
    drain_idle();
    write_step('1);
    run_random(RAND_ITEMS / 6);
    drain_idle();
    write_step(mass_t'($urandom));
    no_idle = 1'b1;
    run_random(RAND_ITEMS / 6);
    no_idle = 1'b0;
    drain_idle();
    write_step(mass_t'($urandom_range(1, 65536)));
    run_random(RAND_ITEMS / 6);
    drain_idle();
    write_step(TS_RESET);
    run_random(RAND_ITEMS - 5 * (RAND_ITEMS / 6));
    drain_idle();
    $display("sent %0d contacts, checked %0d result beats", beats_in, beats_out);
    $display("covered six time_step settings including zero and full scale");
    if (fail_count == 0) begin
      $display("PASS contact_impulse_resolver");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAIL contact_impulse_resolver");
    end
    $finish;
  end

endmodule
